// ===== src/pga_pkg.sv =====
`timescale 1ns / 1ps

package pga_pkg;

   localparam int INDEX_W = 20;
   localparam int DATA_W  = 32;
   localparam int DIFF_W  = 33;
   localparam int ACC_W   = 48;
   localparam int CSR_W   = 3;

   localparam logic [CSR_W-1:0] CSR_TARGET_INDEX  = 3'd0;
   localparam logic [CSR_W-1:0] CSR_TARGET_X      = 3'd1;
   localparam logic [CSR_W-1:0] CSR_TARGET_Y      = 3'd2;
   localparam logic [CSR_W-1:0] CSR_TARGET_Z      = 3'd3;
   localparam logic [CSR_W-1:0] CSR_GRAVITY_CONST = 3'd4;
   localparam logic [CSR_W-1:0] CSR_SOFTEN_SQ     = 3'd5;

   localparam logic [DATA_W-1:0] GRAVITY_RESET = 32'd65536;
   localparam logic [DATA_W-1:0] SOFTEN_RESET  = 32'd655;

   typedef struct packed {
      logic [INDEX_W-1:0]       target_index;
      logic signed [DATA_W-1:0] target_x;
      logic signed [DATA_W-1:0] target_y;
      logic signed [DATA_W-1:0] target_z;
      logic [DATA_W-1:0]        gravity_const;
      logic [DATA_W-1:0]        soften_sq;
   } cfg_type;

   typedef struct packed {
      logic                     skip;
      logic                     last;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [DIFF_W-1:0] dz;
      logic [DATA_W-1:0]        mass;
   } item_type;

endpackage

// ===== src/pairwise_gravity_accumulator.sv =====
`timescale 1ns / 1ps
// In the back end, a body that is not skipped is held longest by the one-bit-per-cycle
// square root and the 64-bit restoring divider; a skipped body goes straight to S_DONE.
// The back end takes a new body only in S_IDLE, once it is through with the last one.
// A two-beat queue lets the input take bodies while the back end is busy.
// Synchronous active-high reset clears the sums, flag and queue and loads CSR defaults.

module pairwise_gravity_accumulator #(
   parameter int INDEX_BITS = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pga_pkg::INDEX_W-1:0]       req_body_index,
   input  logic signed [pga_pkg::DATA_W-1:0] req_body_x,
   input  logic signed [pga_pkg::DATA_W-1:0] req_body_y,
   input  logic signed [pga_pkg::DATA_W-1:0] req_body_z,
   input  logic [pga_pkg::DATA_W-1:0]        req_body_mass,
   input  logic                              req_last_body,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [pga_pkg::ACC_W-1:0]  rsp_accel_x,
   output logic signed [pga_pkg::ACC_W-1:0]  rsp_accel_y,
   output logic signed [pga_pkg::ACC_W-1:0]  rsp_accel_z,
   output logic                              rsp_saturated,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pga_pkg::CSR_W-1:0]         csr_index,
   input  logic [pga_pkg::DATA_W-1:0]        csr_data
);

   pga_pkg::cfg_type  cfg_ff;
   pga_pkg::item_type front_item;
   pga_pkg::item_type queue_item;
   logic              queue_valid;
   logic              back_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_index  <= '0;
         cfg_ff.target_x      <= '0;
         cfg_ff.target_y      <= '0;
         cfg_ff.target_z      <= '0;
         cfg_ff.gravity_const <= pga_pkg::GRAVITY_RESET;
         cfg_ff.soften_sq     <= pga_pkg::SOFTEN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            pga_pkg::CSR_TARGET_INDEX:  cfg_ff.target_index  <= csr_data[pga_pkg::INDEX_W-1:0];
            pga_pkg::CSR_TARGET_X:      cfg_ff.target_x      <= csr_data;
            pga_pkg::CSR_TARGET_Y:      cfg_ff.target_y      <= csr_data;
            pga_pkg::CSR_TARGET_Z:      cfg_ff.target_z      <= csr_data;
            pga_pkg::CSR_GRAVITY_CONST: cfg_ff.gravity_const <= csr_data;
            pga_pkg::CSR_SOFTEN_SQ:     cfg_ff.soften_sq     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   pga_front #(
      .INDEX_BITS(INDEX_BITS)
   ) u_front (
      .cfg        (cfg_ff),
      .body_index (req_body_index),
      .body_x     (req_body_x),
      .body_y     (req_body_y),
      .body_z     (req_body_z),
      .body_mass  (req_body_mass),
      .last_body  (req_last_body),
      .item       (front_item)
   );

   pga_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_valid),
      .wr_ready (req_ready),
      .wr_item  (front_item),
      .rd_valid (queue_valid),
      .rd_ready (back_ready),
      .rd_item  (queue_item)
   );

   pga_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (queue_valid),
      .in_ready      (back_ready),
      .in_item       (queue_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_accel_x   (rsp_accel_x),
      .rsp_accel_y   (rsp_accel_y),
      .rsp_accel_z   (rsp_accel_z),
      .rsp_saturated (rsp_saturated)
   );

endmodule

// ===== src/pga_front.sv =====
`timescale 1ns / 1ps

module pga_front #(
   parameter int INDEX_BITS = 20
) (
   input  pga_pkg::cfg_type                   cfg,
   input  logic [pga_pkg::INDEX_W-1:0]        body_index,
   input  logic signed [pga_pkg::DATA_W-1:0]  body_x,
   input  logic signed [pga_pkg::DATA_W-1:0]  body_y,
   input  logic signed [pga_pkg::DATA_W-1:0]  body_z,
   input  logic [pga_pkg::DATA_W-1:0]         body_mass,
   input  logic                               last_body,
   output pga_pkg::item_type                  item
);

   localparam int CMP_W = (INDEX_BITS < pga_pkg::INDEX_W) ? INDEX_BITS : pga_pkg::INDEX_W;

   always_comb begin
      item.skip = (body_index[CMP_W-1:0] == cfg.target_index[CMP_W-1:0]);
      item.last = last_body;
      item.dx   = pga_pkg::DIFF_W'(body_x) - pga_pkg::DIFF_W'(cfg.target_x);
      item.dy   = pga_pkg::DIFF_W'(body_y) - pga_pkg::DIFF_W'(cfg.target_y);
      item.dz   = pga_pkg::DIFF_W'(body_z) - pga_pkg::DIFF_W'(cfg.target_z);
      item.mass = body_mass;
   end

endmodule

// ===== src/pga_queue.sv =====
`timescale 1ns / 1ps

module pga_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  pga_pkg::item_type wr_item,
   output logic              rd_valid,
   input  logic              rd_ready,
   output pga_pkg::item_type rd_item
);

   pga_pkg::item_type mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   logic       pop;

   assign wr_ready = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_item  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

// ===== src/pga_back.sv =====
`timescale 1ns / 1ps

module pga_back (
   input  logic                              clock,
   input  logic                              reset,
   input  pga_pkg::cfg_type                  cfg,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  pga_pkg::item_type                 in_item,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [pga_pkg::ACC_W-1:0]  rsp_accel_x,
   output logic signed [pga_pkg::ACC_W-1:0]  rsp_accel_y,
   output logic signed [pga_pkg::ACC_W-1:0]  rsp_accel_z,
   output logic                              rsp_saturated
);

   typedef enum logic [4:0] {
      S_IDLE, S_SQX, S_SQY, S_SQZ, S_SQE, S_NUM, S_SQRT, S_R2, S_R3H, S_R3L,
      S_DEN, S_DIV, S_TH, S_TL, S_TMAG, S_ADD, S_DONE
   } state_type;

   localparam logic [47:0] MAG_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic signed [49:0] ACC_MAX = 50'sd140737488355327;
   localparam logic signed [49:0] ACC_MIN = -50'sd140737488355328;

   state_type         state_ff;
   pga_pkg::item_type item_ff;
   logic [63:0]       prod_ff;
   logic [49:0]       s_ff;
   logic [63:0]       num_ff;
   logic [63:0]       x_ff;
   logic [63:0]       res_ff;
   logic [63:0]       bit_ff;
   logic [5:0]        cnt_ff;
   logic [47:0]       r2_ff;
   logic [63:0]       hi_ff;
   logic [63:0]       den_ff;
   logic [63:0]       rem_ff;
   logic [63:0]       quo_ff;
   logic [1:0]        axis_ff;
   logic [63:0]       t_ff;
   logic signed [48:0] term_ff;
   logic              clamp_ff;
   logic signed [47:0] acc_ff [3];
   logic              sat_ff;
   logic              rsp_valid_ff;
   logic signed [47:0] rsp_x_ff;
   logic signed [47:0] rsp_y_ff;
   logic signed [47:0] rsp_z_ff;
   logic              rsp_sat_ff;

   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [32:0] mag_x;
   logic [32:0] mag_y;
   logic [32:0] mag_z;
   logic [32:0] mag_sel;
   logic        neg_sel;
   logic [49:0] s_sum;
   logic [47:0] s_clamped;
   logic [64:0] sq_try;
   logic [64:0] r3_sum;
   logic [63:0] r3_sat;
   logic [64:0] den_sum;
   logic [64:0] div_trial;
   logic [48:0] tm_sum;
   logic [47:0] tm_mag;
   logic        tm_clamp;
   logic signed [49:0] acc_sum;
   logic signed [47:0] acc_new;
   logic        acc_clamp;
   logic        rsp_load;

   function automatic logic [32:0] abs33(input logic signed [32:0] d);
      abs33 = d[32] ? 33'(-d) : 33'(d);
   endfunction

   function automatic logic [31:0] clamp32(input logic [32:0] m);
      clamp32 = m[32] ? 32'hFFFF_FFFF : m[31:0];
   endfunction

   assign mag_x = abs33(item_ff.dx);
   assign mag_y = abs33(item_ff.dy);
   assign mag_z = abs33(item_ff.dz);

   always_comb begin
      case (axis_ff)
         2'd0: begin
            mag_sel = mag_x;
            neg_sel = item_ff.dx[32];
         end
         2'd1: begin
            mag_sel = mag_y;
            neg_sel = item_ff.dy[32];
         end
         default: begin
            mag_sel = mag_z;
            neg_sel = item_ff.dz[32];
         end
      endcase
   end

   always_comb begin
      case (state_ff)
         S_SQX: begin
            mul_a = clamp32(mag_x);
            mul_b = clamp32(mag_x);
         end
         S_SQY: begin
            mul_a = clamp32(mag_y);
            mul_b = clamp32(mag_y);
         end
         S_SQZ: begin
            mul_a = clamp32(mag_z);
            mul_b = clamp32(mag_z);
         end
         S_SQE: begin
            mul_a = cfg.gravity_const;
            mul_b = item_ff.mass;
         end
         S_R2: begin
            mul_a = res_ff[31:0];
            mul_b = res_ff[31:0];
         end
         S_R3H: begin
            mul_a = prod_ff[63:32];
            mul_b = res_ff[31:0];
         end
         S_R3L: begin
            mul_a = {16'd0, r2_ff[15:0]};
            mul_b = res_ff[31:0];
         end
         S_TH: begin
            mul_a = mag_sel[31:0];
            mul_b = quo_ff[63:32];
         end
         S_TL: begin
            mul_a = mag_sel[31:0];
            mul_b = quo_ff[31:0];
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   always_comb begin
      s_sum     = s_ff + 50'(prod_ff[63:16]) + 50'(cfg.soften_sq);
      s_clamped = (s_sum[49:48] != 2'd0) ? MAG_MAX : s_sum[47:0];
      sq_try    = 65'(res_ff) + 65'(bit_ff);
      r3_sum    = 65'(hi_ff) + 65'(prod_ff[63:16]);
      r3_sat    = r3_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : r3_sum[63:0];
      den_sum   = 65'(r3_sat) + 65'(cfg.soften_sq);
      div_trial = {rem_ff, quo_ff[63]};
      tm_sum    = 49'({t_ff[31:0], 16'd0}) + 49'(prod_ff[63:16]);
      if (mag_sel[32]) begin
         tm_clamp = (quo_ff != 64'd0);
         tm_mag   = tm_clamp ? MAG_MAX : 48'd0;
      end else if (t_ff[63:32] != 32'd0 || tm_sum[48]) begin
         tm_clamp = 1'b1;
         tm_mag   = MAG_MAX;
      end else begin
         tm_clamp = 1'b0;
         tm_mag   = tm_sum[47:0];
      end
      acc_sum   = 50'(acc_ff[axis_ff]) + 50'(term_ff);
      acc_clamp = (acc_sum > ACC_MAX) || (acc_sum < ACC_MIN);
      if (acc_sum > ACC_MAX) begin
         acc_new = ACC_MAX[47:0];
      end else if (acc_sum < ACC_MIN) begin
         acc_new = ACC_MIN[47:0];
      end else begin
         acc_new = acc_sum[47:0];
      end
   end

   assign in_ready      = (state_ff == S_IDLE);
   assign rsp_load      = (state_ff == S_DONE) && item_ff.last && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_accel_x   = rsp_x_ff;
   assign rsp_accel_y   = rsp_y_ff;
   assign rsp_accel_z   = rsp_z_ff;
   assign rsp_saturated = rsp_sat_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         sat_ff       <= 1'b0;
         acc_ff[0]    <= '0;
         acc_ff[1]    <= '0;
         acc_ff[2]    <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (in_valid) begin
                  item_ff  <= in_item;
                  state_ff <= in_item.skip ? S_DONE : S_SQX;
               end
            end
            S_SQX: begin
               state_ff <= S_SQY;
            end
            S_SQY: begin
               s_ff     <= 50'(prod_ff[63:16]);
               state_ff <= S_SQZ;
            end
            S_SQZ: begin
               s_ff     <= s_ff + 50'(prod_ff[63:16]);
               state_ff <= S_SQE;
            end
            S_SQE: begin
               s_ff     <= 50'(s_clamped);
               state_ff <= S_NUM;
            end
            S_NUM: begin
               num_ff   <= prod_ff;
               x_ff     <= {s_ff[47:0], 16'd0};
               res_ff   <= 64'd0;
               bit_ff   <= 64'd1 << 62;
               cnt_ff   <= 6'd0;
               state_ff <= S_SQRT;
            end
            S_SQRT: begin
               if (x_ff >= sq_try[63:0]) begin
                  x_ff   <= x_ff - sq_try[63:0];
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd31) begin
                  state_ff <= S_R2;
               end
            end
            S_R2: begin
               state_ff <= S_R3H;
            end
            S_R3H: begin
               r2_ff    <= prod_ff[63:16];
               state_ff <= S_R3L;
            end
            S_R3L: begin
               hi_ff    <= prod_ff;
               state_ff <= S_DEN;
            end
            S_DEN: begin
               den_ff   <= den_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : den_sum[63:0];
               rem_ff   <= 64'd0;
               quo_ff   <= num_ff;
               cnt_ff   <= 6'd0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_trial >= {1'b0, den_ff}) begin
                  rem_ff <= 64'(div_trial - {1'b0, den_ff});
                  quo_ff <= {quo_ff[62:0], 1'b1};
               end else begin
                  rem_ff <= div_trial[63:0];
                  quo_ff <= {quo_ff[62:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  axis_ff  <= 2'd0;
                  state_ff <= S_TH;
               end
            end
            S_TH: begin
               state_ff <= S_TL;
            end
            S_TL: begin
               t_ff     <= prod_ff;
               state_ff <= S_TMAG;
            end
            S_TMAG: begin
               term_ff  <= neg_sel ? -$signed({1'b0, tm_mag}) : $signed({1'b0, tm_mag});
               clamp_ff <= tm_clamp;
               state_ff <= S_ADD;
            end
            S_ADD: begin
               acc_ff[axis_ff] <= acc_new;
               if (clamp_ff || acc_clamp) begin
                  sat_ff <= 1'b1;
               end
               if (axis_ff == 2'd2) begin
                  state_ff <= S_DONE;
               end else begin
                  axis_ff  <= axis_ff + 2'd1;
                  state_ff <= S_TH;
               end
            end
            S_DONE: begin
               if (!item_ff.last) begin
                  state_ff <= S_IDLE;
               end else if (rsp_load) begin
                  rsp_x_ff     <= acc_ff[0];
                  rsp_y_ff     <= acc_ff[1];
                  rsp_z_ff     <= acc_ff[2];
                  rsp_sat_ff   <= sat_ff;
                  acc_ff[0]    <= '0;
                  acc_ff[1]    <= '0;
                  acc_ff[2]    <= '0;
                  sat_ff       <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== src/pga_checker.sv =====
`timescale 1ns / 1ps

module pga_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              req_last_body,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [pga_pkg::ACC_W-1:0]  rsp_accel_x,
   input logic                              rsp_saturated
);

   logic [2:0] pend_ff;
   logic       inc;
   logic       dec;

   assign inc = req_valid && req_ready && req_last_body;
   assign dec = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 3'd0;
      end else if (inc && !dec) begin
         pend_ff <= pend_ff + 3'd1;
      end else if (dec && !inc) begin
         pend_ff <= pend_ff - 3'd1;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accel_x) && $stable(rsp_saturated))
      else $error("stalled result beat changed");

   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 3'd0)
      else $error("result beat without a closing body");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 3'd4)
      else $error("more closing bodies in flight than the design can hold");

endmodule

bind pairwise_gravity_accumulator pga_checker u_pga_checker (.*);

// ===== tb/gravity_checker.sv =====
`timescale 1ns / 1ps

module gravity_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [pga_pkg::INDEX_W-1:0]       req_body_index,
   input  logic signed [pga_pkg::DATA_W-1:0] req_body_x,
   input  logic signed [pga_pkg::DATA_W-1:0] req_body_y,
   input  logic signed [pga_pkg::DATA_W-1:0] req_body_z,
   input  logic [pga_pkg::DATA_W-1:0]        req_body_mass,
   input  logic                              req_last_body,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [pga_pkg::ACC_W-1:0]  rsp_accel_x,
   input  logic signed [pga_pkg::ACC_W-1:0]  rsp_accel_y,
   input  logic signed [pga_pkg::ACC_W-1:0]  rsp_accel_z,
   input  logic                              rsp_saturated,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [pga_pkg::CSR_W-1:0]         csr_index,
   input  logic [pga_pkg::DATA_W-1:0]        csr_data,
   output int                                errors,
   output int                                pending
);

   localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint ACC_LO = -ACC_HI - 64'sd1;
   localparam longint unsigned MASK48 = 64'h0000_FFFF_FFFF_FFFF;
   localparam longint unsigned ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic [pga_pkg::ACC_W-1:0] ax;
      logic [pga_pkg::ACC_W-1:0] ay;
      logic [pga_pkg::ACC_W-1:0] az;
      logic                      sat;
   } accel_type;

   accel_type expected_accels[$];

   logic [pga_pkg::INDEX_W-1:0] tgt_index;
   longint                      tgt_x, tgt_y, tgt_z;
   longint unsigned             grav, eps_sq;
   longint                      acc_x, acc_y, acc_z;
   bit                          acc_sat;

   function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s < a) ? ALL_ONES : s;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned square_q16(longint d);
      longint unsigned m;
      m = (d < 0) ? longint'(-d) : longint'(d);
      if (m >= 64'h1_0000_0000) m = 64'hFFFF_FFFF;
      return (m * m) >> 16;
   endfunction

   function automatic longint unsigned scaled_mag(longint unsigned mag, longint unsigned f,
                                                  output bit clamped);
      longint unsigned t, lo, r;
      clamped = 0;
      if (mag >= 64'h1_0000_0000) begin
         clamped = (f != 0);
         return (f != 0) ? MASK48 : 0;
      end
      t = mag * (f >> 32);
      if (t >= 64'h1_0000_0000) begin
         clamped = 1;
         return MASK48;
      end
      lo = (mag * (f & 64'hFFFF_FFFF)) >> 16;
      r = (t << 16) + lo;
      if (r > MASK48) begin
         clamped = 1;
         return MASK48;
      end
      return r;
   endfunction

   function automatic void fold_term(input longint acc_in, input longint d,
                                     input longint unsigned f,
                                     output longint acc_out, output bit clamped);
      longint unsigned mag;
      longint term, s;
      mag = (d < 0) ? longint'(-d) : longint'(d);
      term = longint'(scaled_mag(mag, f, clamped));
      if (d < 0) term = -term;
      s = acc_in + term;
      if (s > ACC_HI) begin
         s = ACC_HI;
         clamped = 1;
      end
      if (s < ACC_LO) begin
         s = ACC_LO;
         clamped = 1;
      end
      acc_out = s;
   endfunction

   task automatic apply_body();
      longint dx, dy, dz;
      longint unsigned s, r, r2, r3, den, num, f;
      bit cx, cy, cz;
      accel_type e;
      if (req_body_index != tgt_index) begin
         dx = longint'(req_body_x) - tgt_x;
         dy = longint'(req_body_y) - tgt_y;
         dz = longint'(req_body_z) - tgt_z;
         s = square_q16(dx) + square_q16(dy) + square_q16(dz) + eps_sq;
         if (s > MASK48) s = MASK48;
         r = int_sqrt(s << 16);
         r2 = (r * r) >> 16;
         r3 = add_sat((r2 >> 16) * r, ((r2 & 64'hFFFF) * r) >> 16);
         den = add_sat(r3, eps_sq);
         num = grav * longint'(req_body_mass);
         f = (den != 0) ? num / den : ALL_ONES;
         fold_term(acc_x, dx, f, acc_x, cx);
         fold_term(acc_y, dy, f, acc_y, cy);
         fold_term(acc_z, dz, f, acc_z, cz);
         if (cx || cy || cz) acc_sat = 1;
      end
      if (req_last_body) begin
         e.ax = acc_x[pga_pkg::ACC_W-1:0];
         e.ay = acc_y[pga_pkg::ACC_W-1:0];
         e.az = acc_z[pga_pkg::ACC_W-1:0];
         e.sat = acc_sat;
         expected_accels.push_back(e);
         acc_x = 0;
         acc_y = 0;
         acc_z = 0;
         acc_sat = 0;
      end
   endtask

   task automatic compare_accel();
      accel_type e;
      if (expected_accels.size() == 0) begin
         $error("unexpected result beat");
         errors = errors + 1;
      end else begin
         e = expected_accels.pop_front();
         if (rsp_accel_x !== e.ax) begin
            $error("accel_x expected %h actual %h", e.ax, rsp_accel_x);
            errors = errors + 1;
         end
         if (rsp_accel_y !== e.ay) begin
            $error("accel_y expected %h actual %h", e.ay, rsp_accel_y);
            errors = errors + 1;
         end
         if (rsp_accel_z !== e.az) begin
            $error("accel_z expected %h actual %h", e.az, rsp_accel_z);
            errors = errors + 1;
         end
         if (rsp_saturated !== e.sat) begin
            $error("saturated expected %b actual %b", e.sat, rsp_saturated);
            errors = errors + 1;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tgt_index = '0;
         tgt_x = 0;
         tgt_y = 0;
         tgt_z = 0;
         grav = longint'(pga_pkg::GRAVITY_RESET);
         eps_sq = longint'(pga_pkg::SOFTEN_RESET);
         acc_x = 0;
         acc_y = 0;
         acc_z = 0;
         acc_sat = 0;
         expected_accels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pga_pkg::CSR_TARGET_INDEX:  tgt_index = csr_data[pga_pkg::INDEX_W-1:0];
               pga_pkg::CSR_TARGET_X:      tgt_x = longint'(signed'(csr_data));
               pga_pkg::CSR_TARGET_Y:      tgt_y = longint'(signed'(csr_data));
               pga_pkg::CSR_TARGET_Z:      tgt_z = longint'(signed'(csr_data));
               pga_pkg::CSR_GRAVITY_CONST: grav = longint'(csr_data);
               pga_pkg::CSR_SOFTEN_SQ:     eps_sq = longint'(csr_data);
               default: ;
            endcase
         end
         if (req_valid && req_ready) apply_body();
         if (rsp_valid && rsp_ready) compare_accel();
      end
      pending <= expected_accels.size();
   end

endmodule

// ===== tb/pairwise_gravity_accumulator_test.sv =====
`timescale 1ns / 1ps

module pairwise_gravity_accumulator_test;

   localparam logic [pga_pkg::CSR_W-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [pga_pkg::CSR_W-1:0] CSR_SPARE_HIGH = 3'd7;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int DRAIN_CYCLES = 200;
   localparam int BODY_TARGET  = 450;

   logic                              clock = 0;
   logic                              reset = 1;
   logic                              req_valid = 0;
   logic                              req_ready;
   logic [pga_pkg::INDEX_W-1:0]       req_body_index = '0;
   logic signed [pga_pkg::DATA_W-1:0] req_body_x = '0;
   logic signed [pga_pkg::DATA_W-1:0] req_body_y = '0;
   logic signed [pga_pkg::DATA_W-1:0] req_body_z = '0;
   logic [pga_pkg::DATA_W-1:0]        req_body_mass = '0;
   logic                              req_last_body = 0;
   logic                              rsp_valid;
   logic                              rsp_ready = 0;
   logic signed [pga_pkg::ACC_W-1:0]  rsp_accel_x, rsp_accel_y, rsp_accel_z;
   logic                              rsp_saturated;
   logic                              csr_valid = 0;
   logic                              csr_ready;
   logic [pga_pkg::CSR_W-1:0]         csr_index = '0;
   logic [pga_pkg::DATA_W-1:0]        csr_data = '0;
   int                                errors, pending;
   int                                cycles = 0;
   int                                bodies_sent = 0;
   int                                burst_left = 0;
   int                                ready_pct = 100;
   logic [pga_pkg::INDEX_W-1:0]       cur_index;
   logic signed [pga_pkg::DATA_W-1:0] cur_x, cur_y, cur_z;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   pairwise_gravity_accumulator DUT (.*);

   gravity_checker checker_i (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles % 300 == 0) begin
         case ($urandom_range(0, 3))
            0: ready_pct <= 100;
            1: ready_pct <= 70;
            2: ready_pct <= 30;
            default: ready_pct <= 5;
         endcase
      end
      rsp_ready <= ($urandom_range(0, 99) < ready_pct);
      if (cycles >= CYCLE_LIMIT) begin
         $display("** pairwise_gravity_accumulator: FAILED **");
         $finish;
      end
   end

   task automatic write_regs(input logic [pga_pkg::INDEX_W-1:0] idx,
                             input logic [pga_pkg::DATA_W-1:0] tx,
                             input logic [pga_pkg::DATA_W-1:0] ty,
                             input logic [pga_pkg::DATA_W-1:0] tz,
                             input logic [pga_pkg::DATA_W-1:0] grav,
                             input logic [pga_pkg::DATA_W-1:0] eps_sq);
      logic [pga_pkg::CSR_W-1:0] order [7];
      logic [pga_pkg::DATA_W-1:0] vals [7];
      order = '{pga_pkg::CSR_TARGET_INDEX, pga_pkg::CSR_TARGET_X, pga_pkg::CSR_TARGET_Y,
                pga_pkg::CSR_TARGET_Z, pga_pkg::CSR_GRAVITY_CONST, pga_pkg::CSR_SOFTEN_SQ,
                $urandom_range(0, 1) ? CSR_SPARE_LOW : CSR_SPARE_HIGH};
      vals = '{pga_pkg::DATA_W'(idx), tx, ty, tz, grav, eps_sq, $urandom};
      for (int i = 0; i < 7; i++) begin
         csr_valid <= 1;
         csr_index <= order[i];
         csr_data <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 0;
      cur_index = idx;
      cur_x = tx;
      cur_y = ty;
      cur_z = tz;
   endtask

   task automatic settle();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_body(input logic [pga_pkg::INDEX_W-1:0] idx,
                            input logic [pga_pkg::DATA_W-1:0] x,
                            input logic [pga_pkg::DATA_W-1:0] y,
                            input logic [pga_pkg::DATA_W-1:0] z,
                            input logic [pga_pkg::DATA_W-1:0] mass, input logic last);
      req_valid <= 1;
      req_body_index <= idx;
      req_body_x <= x;
      req_body_y <= y;
      req_body_z <= z;
      req_body_mass <= mass;
      req_last_body <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bodies_sent++;
      if (burst_left == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(0, 3) == 0 ? 30 : $urandom_range(1, 6);
      end else begin
         burst_left--;
      end
   endtask

   function automatic logic [pga_pkg::DATA_W-1:0] pick_coord(
      input logic [pga_pkg::DATA_W-1:0] center);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5:
            return center + pga_pkg::DATA_W'($urandom_range(0, 2 ** 22)) - 32'h0020_0000;
         6, 7, 8: return $urandom;
         default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
   endfunction

   function automatic logic [pga_pkg::DATA_W-1:0] pick_mass();
      case ($urandom_range(0, 9))
         0: return '0;
         1, 2: return $urandom;
         default: return $urandom_range(0, 32'h0010_0000);
      endcase
   endfunction

   function automatic logic [pga_pkg::DATA_W-1:0] pick_cfg(
      input logic [pga_pkg::DATA_W-1:0] usual);
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return $urandom;
         3: return $urandom_range(0, 32'h0004_0000);
         default: return usual;
      endcase
   endfunction

   initial begin
      logic [pga_pkg::INDEX_W-1:0] idx;
      int sweep_len;
      repeat (12) @(posedge clock);
      reset <= 0;
      repeat (3) @(posedge clock);

      send_body(20'd1, 32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000, 0);
      send_body(20'd2, 32'hFFFF_0000, 32'h0002_0000, 32'hFFFD_0000, 32'h0000_8000, 0);
      send_body(20'd0, 32'h1234_5678, 32'd5, 32'd6, 32'hFFFF_FFFF, 0);
      send_body(20'hFFFFF, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 1);
      send_body(20'd0, 32'd1, 32'd1, 32'd1, 32'h0001_0000, 1);
      send_body(20'd3, 32'h0000_0100, 32'h0000_0001, 32'hFFFF_FFFF, 32'd0, 1);
      settle();

      write_regs(20'hFFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '1, '1);
      send_body(20'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '1, 0);
      send_body(20'hFFFFE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '1, 0);
      send_body(20'h55555, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '1, 1);
      send_body(20'hFFFFF, 32'd0, 32'd0, 32'd0, '1, 1);
      settle();

      write_regs(20'hAAAAA, 32'd0, 32'd0, 32'd0, 32'h0001_0000, '0);
      send_body(20'h12345, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 0);
      send_body(20'h12346, 32'h0000_0001, 32'd0, 32'd0, '1, 0);
      send_body(20'h12347, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, 1);
      send_body(20'hAAAAA, 32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000, 1);
      settle();

      write_regs(20'd7, 32'h0001_0000, 32'hFFFF_0000, 32'd0, '0, 32'd655);
      send_body(20'd8, 32'h0010_0000, 32'd0, 32'd0, '1, 0);
      send_body(20'd9, 32'hFFF0_0000, 32'd0, 32'd0, 32'h0001_0000, 1);
      settle();

      while (bodies_sent < BODY_TARGET) begin
         write_regs(pga_pkg::INDEX_W'($urandom), pick_cfg($urandom), pick_cfg($urandom),
                    pick_cfg($urandom), pick_cfg(32'h0001_0000), pick_cfg(32'd655));
         for (int p = 0; p < 8 && bodies_sent < BODY_TARGET; p++) begin
            sweep_len = $urandom_range(0, 4) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 10);
            for (int k = 0; k < sweep_len; k++) begin
               idx = ($urandom_range(0, 9) == 0) ? cur_index : pga_pkg::INDEX_W'($urandom);
               send_body(idx, pick_coord(cur_x), pick_coord(cur_y), pick_coord(cur_z),
                         pick_mass(), k == sweep_len - 1);
            end
         end
         settle();
      end

      settle();
      if (errors == 0) begin
         $display("** pairwise_gravity_accumulator: PASSED **");
      end else begin
         $display("** pairwise_gravity_accumulator: FAILED **");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/pga_pkg.sv
src/pga_front.sv
src/pga_queue.sv
src/pga_back.sv
src/pairwise_gravity_accumulator.sv
src/pga_checker.sv
tb/gravity_checker.sv
tb/pairwise_gravity_accumulator_test.sv
